// ----- hdl/dfh_pkg.sv -----
// dfh_pkg: shared types, constants and the elaboration-time log2 helper
// for the dew point pipeline. no dependencies.
package dfh_pkg;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_SAT_LOW = 2'd2
    } status_t;

    localparam logic [13:0] HUM_FULL = 14'd10000;
    localparam longint LN2_Q30 = 64'sd744261118;
    localparam longint DEW_LOW = -64'sd10000;
    localparam longint DEW_HIGH = 64'sd16383;

    // temperature term operands, travel alongside the log path
    typedef struct packed {
        logic        zero;
        logic        tneg;
        logic [26:0] tnum;
        logic [21:0] tden;
    } tside_t;

    // after the temperature divider
    typedef struct packed {
        logic               zero;
        logic signed [33:0] ln;
    } lside_t;

    // dew point divider sideband
    typedef struct packed {
        logic zero;
        logic kneg;
    } kside_t;

    // log2 of x in q30, x in [1, 2], answer in q28 by repeated squaring
    function automatic logic [63:0] log2_q30(input logic [63:0] xin);
        logic [63:0] x;
        logic [63:0] r;
        begin
            x = xin;
            r = '0;
            if (x >= (64'd2 << 30))
            begin
                r = 64'd1 << 28;
                x = x >> 1;
            end
            for (int b = 27; b >= 0; b--)
            begin
                x = (x * x + (64'd1 << 29)) >> 30;
                if (x >= (64'd2 << 30))
                begin
                    x = x >> 1;
                    r[b] = 1'b1;
                end
            end
            return r;
        end
    endfunction

endpackage

// ----- hdl/dfh_in_if.sv -----
// dfh_in_if: input channel, humidity and temperature with valid/ready
// depends on nothing
interface dfh_in_if;
    logic               valid;
    logic               ready;
    logic        [13:0] humidity;
    logic signed [14:0] temperature;

    modport source (output valid, output humidity, output temperature, input ready);
    modport sink (input valid, input humidity, input temperature, output ready);
endinterface

// ----- hdl/dfh_out_if.sv -----
// dfh_out_if: result channel, dew point and status with valid/ready
// depends on nothing
interface dfh_out_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] dewpoint;
    logic        [1:0]  status;

    modport source (output valid, output dewpoint, output status, input ready);
    modport sink (input valid, input dewpoint, input status, output ready);
endinterface

// ----- hdl/dfh_div.sv -----
// dfh_div: pipelined restoring divider, one quotient bit per stage
// depends on nothing; caller guarantees num < den * 2**QW
module dfh_div #(
    parameter int NW = 56,
    parameter int DW = 22,
    parameter int QW = 35,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic [SW-1:0] side_out
);
    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] lo_reg   [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [SW-1:0] side_reg [QW];
    logic [QW-1:0] v_reg;

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        logic [DW-1:0] rem_in;
        logic [QW-1:0] lo_in;
        logic [QW-1:0] quo_in;
        logic [DW-1:0] den_in;
        logic [SW-1:0] side_s;
        logic          v_in;
        logic [DW:0]   r2;
        logic          ge;
        logic [DW-1:0] rem_next;

        if (s == 0)
        begin : g_first
            assign rem_in = DW'(num[NW-1:QW]);
            assign lo_in  = num[QW-1:0];
            assign quo_in = '0;
            assign den_in = den;
            assign side_s = side_in;
            assign v_in   = in_valid;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign lo_in  = lo_reg[s-1];
            assign quo_in = quo_reg[s-1];
            assign den_in = den_reg[s-1];
            assign side_s = side_reg[s-1];
            assign v_in   = v_reg[s-1];
        end

        assign r2 = {rem_in, lo_in[QW-1]};
        assign ge = (r2 >= {1'b0, den_in});
        assign rem_next = ge ? DW'(r2 - {1'b0, den_in}) : DW'(r2);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                lo_reg[s]   <= lo_in << 1;
                quo_reg[s]  <= {quo_in[QW-2:0], ge};
                den_reg[s]  <= den_in;
                side_reg[s] <= side_s;
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign quo       = quo_reg[QW-1];
    assign side_out  = side_reg[QW-1];
endmodule

// ----- hdl/dfh_log2.sv -----
// dfh_log2: five-stage ln(h/10000) in q28, table lookup with interpolation
// depends on dfh_pkg
module dfh_log2
    import dfh_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int SW = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [13:0]        humidity,
    input  logic [SW-1:0]      side_in,
    output logic               out_valid,
    output logic signed [33:0] ln,
    output logic [SW-1:0]      side_out
);
    localparam int SCW = 30 + $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int TW = $clog2(DEPTH + 1);

    // log2(10000) worked out the same way as the datapath
    localparam logic [63:0] L10_F = 64'd236978176;
    localparam logic [63:0] L10_SC = L10_F * DEPTH;
    localparam logic [63:0] L10_IDX = L10_SC >> 30;
    localparam logic [63:0] L10_FRAC = L10_SC & ((64'd1 << 30) - 64'd1);
    localparam logic [63:0] L10_B0 = log2_q30((64'd1 << 30) + (L10_IDX << 30) / DEPTH);
    localparam logic [63:0] L10_B1 =
        log2_q30((64'd1 << 30) + ((L10_IDX + 64'd1) << 30) / DEPTH);
    localparam logic [63:0] L10_STEP =
        ((L10_B1 - L10_B0) * L10_FRAC + (64'd1 << 29)) >> 30;
    localparam logic [63:0] L10K = (64'd13 << 28) + L10_B0 + L10_STEP;

    logic [28:0] tab [DEPTH+1];

    for (genvar gi = 0; gi <= DEPTH; gi++)
    begin : g_tab
        localparam logic [63:0] ENT =
            log2_q30((64'd1 << 30) + (64'(gi) << 30) / DEPTH);
        assign tab[gi] = ENT[28:0];
    end

    // stage 1: exponent, mantissa, table index
    logic [3:0]     e;
    logic [30:0]    sh;
    logic [SCW-1:0] scaled;
    logic [SCW-31:0] idx_raw;
    logic [IW-1:0]  idx;

    always_comb
    begin
        e = '0;
        for (int i = 1; i < 14; i++)
        begin
            if (humidity[i])
            begin
                e = 4'(i);
            end
        end
        sh      = 31'(humidity) << (5'd30 - 5'(e));
        scaled  = SCW'(sh[29:0]) * SCW'(DEPTH);
        idx_raw = scaled[SCW-1:30];
        if (idx_raw >= (SCW-30)'(DEPTH))
        begin
            idx = IW'(DEPTH - 1);
        end
        else
        begin
            idx = IW'(idx_raw);
        end
    end

    logic [4:0]    v_reg;
    logic [3:0]    e1_reg;
    logic [IW-1:0] idx1_reg;
    logic [29:0]   frac1_reg;
    logic [SW-1:0] side1_reg;

    // stage 2: table reads
    logic [3:0]    e2_reg;
    logic [28:0]   base2_reg;
    logic [28:0]   diff2_reg;
    logic [29:0]   frac2_reg;
    logic [SW-1:0] side2_reg;
    logic [TW-1:0] ia;
    logic [TW-1:0] ib;

    assign ia = TW'(idx1_reg);
    assign ib = TW'(idx1_reg) + TW'(1);

    // stage 3: interpolation
    logic [58:0] sp;
    logic [31:0] log2_next;
    logic [31:0] log2_3_reg;
    logic [SW-1:0] side3_reg;

    assign sp = 59'(diff2_reg) * 59'(frac2_reg) + (59'd1 << 29);
    assign log2_next = {e2_reg, 28'd0} + 32'(base2_reg) + 32'(sp[58:30]);

    // stage 4: scale by ln 2
    logic signed [32:0] lnd;
    logic signed [63:0] prod4_reg;
    logic [SW-1:0]      side4_reg;

    assign lnd = $signed({1'b0, log2_3_reg}) - $signed(33'(L10K));

    // stage 5: round to q28, half away from zero
    logic [62:0]        pm;
    logic [62:0]        pq;
    logic signed [33:0] ln_next;
    logic signed [33:0] ln5_reg;
    logic [SW-1:0]      side5_reg;

    always_comb
    begin
        pm = prod4_reg[63] ? 63'(-prod4_reg) : 63'(prod4_reg);
        pq = (pm + (63'd1 << 29)) >> 30;
        ln_next = prod4_reg[63] ? -$signed(34'(pq)) : $signed(34'(pq));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_reg     <= e;
            idx1_reg   <= idx;
            frac1_reg  <= scaled[29:0];
            side1_reg  <= side_in;
            e2_reg     <= e1_reg;
            base2_reg  <= tab[ia];
            diff2_reg  <= tab[ib] - tab[ia];
            frac2_reg  <= frac1_reg;
            side2_reg  <= side1_reg;
            log2_3_reg <= log2_next;
            side3_reg  <= side2_reg;
            prod4_reg  <= 64'(lnd) * LN2_Q30;
            side4_reg  <= side3_reg;
            ln5_reg    <= ln_next;
            side5_reg  <= side4_reg;
        end
    end

    assign out_valid = v_reg[4];
    assign ln        = ln5_reg;
    assign side_out  = side5_reg;
endmodule

// ----- hdl/dewpoint_from_humidity_top.sv -----
// dew point from relative humidity and temperature, magnus formula.
// one item enters on the sample channel (humidity in 0.01 %, temperature
// in 0.01 degC); one item leaves on the result channel (dew point in
// 0.01 degC and a status: ok, humidity zero, or saturated at -100 degC).
// a humidity above 100 % is clipped to 100 % before use.
// from acceptance to result valid an item passes five stages of log2
// lookup and scaling, a 35-stage divider for the temperature term,
// two stages forming k, a 17-stage divider for the dew point and the
// output register. throughput is one item per cycle while the receiver takes
// results, set by the fully pipelined dividers (one quotient bit per stage).
// the whole pipeline advances together: while the result is held by the
// receiver every stage holds, and sample.ready goes low in the same cycle,
// so nothing is lost or repeated. reset clears all valid bits; the log
// table is constant logic and needs no fill.
// depends on dfh_pkg, dfh_in_if, dfh_out_if, dfh_log2 and dfh_div
module dewpoint_from_humidity_top
    import dfh_pkg::*;
#(
    parameter int LOG_TABLE_DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    dfh_in_if.sink     sample,
    dfh_out_if.source  result
);
    localparam int TSW = $bits(tside_t);
    localparam int LSW = $bits(lside_t);
    localparam int KSW = $bits(kside_t);

    logic en;
    logic out_v_reg;

    assign en = !out_v_reg || result.ready;
    assign sample.ready = en;

    // front: clip humidity, temperature term operands
    logic [13:0]        hsat;
    logic [15:0]        tabs;
    tside_t             ts_in;
    logic signed [16:0] tsum;

    always_comb
    begin
        hsat = (sample.humidity > HUM_FULL) ? HUM_FULL : sample.humidity;
        tabs = sample.temperature[14] ? 16'(-17'(sample.temperature))
                                      : 16'(sample.temperature);
        tsum = 17'sd24312 + 17'(sample.temperature);
        ts_in.zero = (sample.humidity == '0);
        ts_in.tneg = sample.temperature[14];
        ts_in.tnum = 27'(tabs) * 27'd1762;
        ts_in.tden = 22'(tsum) * 22'd100;
    end

    logic               lg_v;
    logic signed [33:0] lg_ln;
    logic [TSW-1:0]     lg_side;

    dfh_log2 #(
        .DEPTH (LOG_TABLE_DEPTH),
        .SW    (TSW)
    ) u_log2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sample.valid),
        .humidity  (hsat),
        .side_in   (ts_in),
        .out_valid (lg_v),
        .ln        (lg_ln),
        .side_out  (lg_side)
    );

    tside_t      ts_l;
    lside_t      ls_in;
    logic [55:0] num1;

    assign ts_l = tside_t'(lg_side);
    assign ls_in.zero = ts_l.zero;
    assign ls_in.ln   = lg_ln;
    assign num1 = {ts_l.tnum, 29'd0} - {1'b0, ts_l.tnum, 28'd0}
                + 56'(ts_l.tden >> 1);

    logic           d1_v;
    logic [34:0]    d1_q;
    logic [LSW-1:0] d1_side_raw;
    logic [LSW:0]   d1_side;

    dfh_div #(
        .NW (56),
        .DW (22),
        .QW (35),
        .SW (LSW + 1)
    ) u_div_term (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (lg_v),
        .num       (num1),
        .den       (ts_l.tden),
        .side_in   ({ts_l.tneg, ls_in}),
        .out_valid (d1_v),
        .quo       (d1_q),
        .side_out  (d1_side)
    );

    assign d1_side_raw = d1_side[LSW-1:0];

    // k = ln + temperature term, q28
    lside_t             ls_out;
    logic signed [35:0] term;
    logic signed [36:0] k_reg;
    logic               kz_reg;
    logic               kv_reg;

    assign ls_out = lside_t'(d1_side_raw);
    assign term = d1_side[LSW] ? -$signed(36'(d1_q)) : $signed(36'(d1_q));

    // numerator and denominator of the dew point quotient
    logic        kneg;
    logic [35:0] kmag;
    logic signed [43:0] den_full;
    logic [41:0] den2;
    logic [57:0] num2;
    logic [57:0] num2_reg;
    logic [41:0] den2_reg;
    kside_t      ks_reg;
    logic        nv_reg;

    always_comb
    begin
        kneg = k_reg[36];
        kmag = kneg ? 36'(-k_reg) : 36'(k_reg);
        den_full = (44'sd1762 <<< 28) - 44'sd100 * 44'(k_reg);
        den2 = den_full[41:0];
        num2 = 58'(kmag) * 58'd2431200 + 58'(den2 >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kv_reg <= 1'b0;
            nv_reg <= 1'b0;
        end
        else if (en)
        begin
            kv_reg <= d1_v;
            nv_reg <= kv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k_reg     <= 37'(ls_out.ln) + 37'(term);
            kz_reg    <= ls_out.zero;
            num2_reg  <= num2;
            den2_reg  <= den2;
            ks_reg.zero <= kz_reg;
            ks_reg.kneg <= kneg;
        end
    end

    logic           d2_v;
    logic [16:0]    d2_q;
    logic [KSW-1:0] d2_side;
    kside_t         ks_out;

    dfh_div #(
        .NW (58),
        .DW (42),
        .QW (17),
        .SW (KSW)
    ) u_div_dew (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (nv_reg),
        .num       (num2_reg),
        .den       (den2_reg),
        .side_in   (ks_reg),
        .out_valid (d2_v),
        .quo       (d2_q),
        .side_out  (d2_side)
    );

    assign ks_out = kside_t'(d2_side);

    // sign, saturation and status
    logic signed [17:0] dew;
    logic signed [14:0] dew_next;
    status_t            st_next;
    logic signed [14:0] dew_reg;
    status_t            st_reg;

    always_comb
    begin
        dew = ks_out.kneg ? -$signed(18'(d2_q)) : $signed(18'(d2_q));
        if (ks_out.zero)
        begin
            dew_next = '0;
            st_next  = ST_INVALID;
        end
        else if (dew < 18'(DEW_LOW))
        begin
            dew_next = 15'(DEW_LOW);
            st_next  = ST_SAT_LOW;
        end
        else if (dew > 18'(DEW_HIGH))
        begin
            dew_next = 15'(DEW_HIGH);
            st_next  = ST_OK;
        end
        else
        begin
            dew_next = dew[14:0];
            st_next  = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= d2_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dew_reg <= dew_next;
            st_reg  <= st_next;
        end
    end

    assign result.valid    = out_v_reg;
    assign result.dewpoint = dew_reg;
    assign result.status   = st_reg;

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |-> !sample.ready)
        else $error("input taken while result stalled");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status == ST_INVALID) |-> result.dewpoint == 15'sd0)
        else $error("invalid item with nonzero dew point");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status == ST_SAT_LOW) |-> result.dewpoint == -15'sd10000)
        else $error("saturated item with wrong dew point");

    a_floor: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.dewpoint >= -15'sd10000)
        else $error("dew point below floor");
endmodule
